@@ rtl/joint_trajectory_interpolator_macros.svh @@
// Assertion helpers for the checker file.
`ifndef JOINT_TRAJECTORY_INTERPOLATOR_MACROS_SVH
`define JOINT_TRAJECTORY_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define JTI_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define JTI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/jti_pkg.sv @@
package jti_pkg;

  // Default field widths
  localparam int ANGLE_WIDTH_DEF = 16;
  localparam int RATE_WIDTH_DEF  = 24;
  localparam int TIME_WIDTH_DEF  = 16;

  // Working word: signed, QFRAC fractional bits
  localparam int QW         = 64;
  localparam int QFRAC      = 24;
  localparam int CLAMP_BITS = 40;
  localparam int ANGLE_IBITS = 3;

  // Shared multiplier: signed operand y, 32-bit magnitude slices
  localparam int MUL_HALF = QW / 2;
  localparam int MUL_YW   = MUL_HALF + 1;

  // Divider step counter
  localparam int DIV_CNT_W = $clog2(QW + 1);

  localparam int DURATION_RESET  = 60;
  localparam int REG_INDEX_WIDTH = 3;

  localparam logic signed [QW-1:0] Q_ONE   = QW'(1);
  localparam logic signed [QW-1:0] Q_CLAMP = Q_ONE <<< CLAMP_BITS;

  // Configuration register indexes
  typedef enum logic [REG_INDEX_WIDTH-1:0] {
    REG_MODE        = 3'd0,
    REG_DURATION    = 3'd1,
    REG_START_ANGLE = 3'd2,
    REG_END_ANGLE   = 3'd3,
    REG_START_RATE  = 3'd4,
    REG_END_RATE    = 3'd5,
    REG_LOWER_LIMIT = 3'd6,
    REG_UPPER_LIMIT = 3'd7
  } cfg_reg_t;

  // Fault codes
  localparam logic [1:0] FAULT_NONE    = 2'd0;
  localparam logic [1:0] FAULT_REQUEST = 2'd1;
  localparam logic [1:0] FAULT_PATH    = 2'd2;

  typedef struct packed {
    logic start;
    logic frac;
  } mul_req_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] count;
  } div_req_t;

  // Widen a field with frac fractional bits to the working format
  function automatic logic signed [QW-1:0] to_q(input logic signed [QW-1:0] v,
                                                input int frac);
    logic signed [QW-1:0] bias;
    bias = '0;
    if (frac <= QFRAC) begin
      return v <<< (QFRAC - frac);
    end
    if (v < 0) begin
      bias = (Q_ONE <<< (frac - QFRAC)) - Q_ONE;
    end
    return (v + bias) >>> (frac - QFRAC);
  endfunction

  // Clamp and convert a working value to frac fractional bits, toward zero
  function automatic logic signed [QW-1:0] from_q(input logic signed [QW-1:0] x,
                                                  input int frac);
    logic signed [QW-1:0] c;
    logic signed [QW-1:0] bias;
    bias = '0;
    c = (x > Q_CLAMP) ? Q_CLAMP : ((x < -Q_CLAMP) ? -Q_CLAMP : x);
    if (frac >= QFRAC) begin
      return c <<< (frac - QFRAC);
    end
    if (c < 0) begin
      bias = (Q_ONE <<< (QFRAC - frac)) - Q_ONE;
    end
    return (c + bias) >>> (QFRAC - frac);
  endfunction

  // Saturate to a signed field of w bits
  function automatic logic signed [QW-1:0] sat_q(input logic signed [QW-1:0] x,
                                                 input int w);
    logic signed [QW-1:0] hi;
    logic signed [QW-1:0] lo;
    hi = (Q_ONE <<< (w - 1)) - Q_ONE;
    lo = -hi - Q_ONE;
    return (x > hi) ? hi : ((x < lo) ? lo : x);
  endfunction

endpackage

@@ rtl/joint_trajectory_interpolator.sv @@
// Channel   Direction  Handshake            Payload
// in        in         in_valid/in_ready    restart
// out       out        out_valid/out_ready  position, rate, fault, done_res
// cfg       in         cfg_write            cfg_index, cfg_data
//
// Hold, fault and finish ticks go straight to emit. A linear sample computes one
// product and a cubic sample nine: the bit-serial divider forms 24 quotient bits
// for the time fraction and 64 for the rate, and each product passes through
// the single 32x32 multiplier.
// rst is synchronous and restores the register reset values and the done phase.
// in_ready is high only between items; a finished result waits in the output
// register while the next item is taken.
module joint_trajectory_interpolator #(
  parameter int ANGLE_WIDTH = jti_pkg::ANGLE_WIDTH_DEF,
  parameter int RATE_WIDTH  = jti_pkg::RATE_WIDTH_DEF,
  parameter int TIME_WIDTH  = jti_pkg::TIME_WIDTH_DEF,
  localparam int CFG_W = (RATE_WIDTH >= ANGLE_WIDTH)
                         ? ((RATE_WIDTH >= TIME_WIDTH) ? RATE_WIDTH : TIME_WIDTH)
                         : ((ANGLE_WIDTH >= TIME_WIDTH) ? ANGLE_WIDTH : TIME_WIDTH)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 restart,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [ANGLE_WIDTH-1:0]        position,
  output logic signed [RATE_WIDTH-1:0]         rate,
  output logic [1:0]                           fault,
  output logic                                 done_res,
  input  logic                                 cfg_write,
  input  logic [jti_pkg::REG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [CFG_W-1:0]                     cfg_data
);

  localparam int QW    = jti_pkg::QW;
  localparam int QFRAC = jti_pkg::QFRAC;
  localparam int YW    = jti_pkg::MUL_YW;
  localparam int CW    = jti_pkg::DIV_CNT_W;
  localparam int AFRAC = ANGLE_WIDTH - jti_pkg::ANGLE_IBITS;
  localparam int RFRAC = RATE_WIDTH - jti_pkg::ANGLE_IBITS;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SSTART = 9'b000000010,
    S_SWAIT  = 9'b000000100,
    S_MSTART = 9'b000001000,
    S_MWAIT  = 9'b000010000,
    S_RSTART = 9'b000100000,
    S_RWAIT  = 9'b001000000,
    S_FIN    = 9'b010000000,
    S_EMIT   = 9'b100000000
  } state_t;

  typedef enum logic [3:0] {
    PH_DONE    = 4'b0001,
    PH_RUN     = 4'b0010,
    PH_BADREQ  = 4'b0100,
    PH_BADPATH = 4'b1000
  } phase_t;

  // Product order; linear moves stop after OP_DS
  typedef enum logic [3:0] {
    OP_DS   = 4'd0,
    OP_VT0  = 4'd1,
    OP_VT1  = 4'd2,
    OP_AU   = 4'd3,
    OP_BS   = 4'd4,
    OP_SU   = 4'd5,
    OP_BLSU = 4'd6,
    OP_BLUS = 4'd7,
    OP_BASU = 4'd8
  } op_t;

  // Configuration registers
  logic                          mode;
  logic [TIME_WIDTH-1:0]         duration_ticks;
  logic signed [ANGLE_WIDTH-1:0] start_angle;
  logic signed [ANGLE_WIDTH-1:0] end_angle;
  logic signed [RATE_WIDTH-1:0]  start_rate;
  logic signed [RATE_WIDTH-1:0]  end_rate;
  logic signed [ANGLE_WIDTH-1:0] lower_limit;
  logic signed [ANGLE_WIDTH-1:0] upper_limit;

  // Move state
  state_t                        st;
  phase_t                        phase;
  logic [TIME_WIDTH-1:0]         elapsed;
  logic signed [ANGLE_WIDTH-1:0] held_position;

  // Working registers
  op_t                           op;
  logic [TIME_WIDTH-1:0]         kq;
  logic [QFRAC-1:0]              s_frac;
  logic [QFRAC:0]                su;
  logic signed [QW-1:0]          a_r;
  logic signed [QW-1:0]          b_r;
  logic signed [QW-1:0]          blend;
  logic signed [QW-1:0]          pacc;
  logic signed [QW-1:0]          num;
  logic signed [QW-1:0]          r_q;
  logic signed [ANGLE_WIDTH-1:0] st_pos;
  logic signed [RATE_WIDTH-1:0]  st_rate;
  logic [1:0]                    st_fault;
  logic                          st_done;

  // Datapath signals
  logic signed [QW-1:0]          q0_q;
  logic signed [QW-1:0]          q1_q;
  logic signed [QW-1:0]          d_q;
  logic signed [QW-1:0]          v0_q;
  logic signed [QW-1:0]          v1_q;
  logic signed [YW-1:0]          t_y;
  logic [QFRAC:0]                u_w;
  logic signed [QFRAC+1:0]       us_diff;
  logic [QW-1:0]                 num_mag;
  logic signed [QW-1:0]          pos_raw;
  logic signed [QW-1:0]          pos_sat;
  logic signed [QW-1:0]          rate_sat;
  logic                          path_bad;
  logic                          accept;
  logic                          restart_bad;
  logic                          run_end;
  logic [1:0]                    acc_fault;
  logic                          acc_done;
  logic                          out_free;

  jti_pkg::mul_req_t             mul_req;
  logic signed [QW-1:0]          mul_x;
  logic signed [YW-1:0]          mul_y;
  logic                          mul_done;
  logic signed [QW-1:0]          mul_res;

  jti_pkg::div_req_t             div_req;
  logic [TIME_WIDTH-1:0]         div_rem;
  logic [QW-1:0]                 div_num;
  logic                          div_done;
  logic [QW-1:0]                 div_quot;

  assign in_ready = (st == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Operands in the working format
  always_comb begin
    q0_q    = jti_pkg::to_q(QW'(start_angle), AFRAC);
    q1_q    = jti_pkg::to_q(QW'(end_angle), AFRAC);
    d_q     = q1_q - q0_q;
    v0_q    = jti_pkg::to_q(QW'(start_rate), RFRAC);
    v1_q    = jti_pkg::to_q(QW'(end_rate), RFRAC);
    t_y     = $signed(YW'(duration_ticks));
    u_w     = {1'b1, QFRAC'(0)} - {1'b0, s_frac};
    us_diff = $signed({1'b0, u_w}) - $signed({2'b00, s_frac});
    num_mag = num[QW-1] ? QW'(-num) : QW'(num);
  end

  // Decide the item on transfer
  always_comb begin
    restart_bad = (duration_ticks == '0) ||
                  (start_angle < lower_limit) || (start_angle > upper_limit) ||
                  (end_angle < lower_limit) || (end_angle > upper_limit);
    run_end     = (duration_ticks == '0) || (elapsed >= duration_ticks);
    acc_fault   = jti_pkg::FAULT_NONE;
    acc_done    = 1'b0;
    if (restart) begin
      acc_fault = jti_pkg::FAULT_REQUEST;
    end else begin
      case (phase)
        PH_RUN:     acc_done  = 1'b1;
        PH_BADREQ:  acc_fault = jti_pkg::FAULT_REQUEST;
        PH_BADPATH: acc_fault = jti_pkg::FAULT_PATH;
        PH_DONE:    acc_done  = 1'b1;
        default:    acc_done  = 1'b1;
      endcase
    end
  end

  // Final conversion and limit test
  always_comb begin
    pos_raw  = jti_pkg::from_q(pacc, AFRAC);
    path_bad = mode && ((pos_raw < QW'(lower_limit)) || (pos_raw > QW'(upper_limit)));
    pos_sat  = jti_pkg::sat_q(pos_raw, ANGLE_WIDTH);
    rate_sat = jti_pkg::sat_q(jti_pkg::from_q(r_q, RFRAC), RATE_WIDTH);
  end

  // Select multiplier operands for the current product
  always_comb begin
    mul_req.start = (st == S_MSTART);
    mul_req.frac  = 1'b1;
    mul_x         = d_q;
    mul_y         = $signed(YW'(s_frac));
    case (op)
      OP_DS: begin
        mul_x = d_q;
        mul_y = $signed(YW'(s_frac));
      end
      OP_VT0: begin
        mul_x        = v0_q;
        mul_y        = t_y;
        mul_req.frac = 1'b0;
      end
      OP_VT1: begin
        mul_x        = v1_q;
        mul_y        = t_y;
        mul_req.frac = 1'b0;
      end
      OP_AU: begin
        mul_x = a_r;
        mul_y = $signed(YW'(u_w));
      end
      OP_BS: begin
        mul_x = b_r;
        mul_y = $signed(YW'(s_frac));
      end
      OP_SU: begin
        mul_x = $signed(QW'(s_frac));
        mul_y = $signed(YW'(u_w));
      end
      OP_BLSU: begin
        mul_x = blend;
        mul_y = $signed(YW'(su));
      end
      OP_BLUS: begin
        mul_x = blend;
        mul_y = YW'(us_diff);
      end
      OP_BASU: begin
        mul_x = b_r - a_r;
        mul_y = $signed(YW'(su));
      end
      default: ;
    endcase
  end

  // Divider: time fraction first, then the rate quotient
  always_comb begin
    div_req.start = (st == S_SSTART) || (st == S_RSTART);
    div_req.count = (st == S_SSTART) ? CW'(QFRAC) : CW'(QW);
    div_rem       = (st == S_SSTART) ? kq : '0;
    div_num       = (st == S_SSTART) ? '0 : num_mag;
  end

  jti_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .req    (mul_req),
    .x      (mul_x),
    .y      (mul_y),
    .done   (mul_done),
    .result (mul_res)
  );

  jti_div #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .rem_init (div_rem),
    .num      (div_num),
    .divisor  (duration_ticks),
    .done     (div_done),
    .quot     (div_quot)
  );

  // Sequencer, move state, configuration and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      st             <= S_IDLE;
      phase          <= PH_DONE;
      elapsed        <= '0;
      held_position  <= '0;
      out_valid      <= 1'b0;
      mode           <= 1'b0;
      duration_ticks <= TIME_WIDTH'(jti_pkg::DURATION_RESET);
      start_angle    <= '0;
      end_angle      <= '0;
      start_rate     <= '0;
      end_rate       <= '0;
      lower_limit    <= {1'b1, (ANGLE_WIDTH-1)'(0)};
      upper_limit    <= {1'b0, {(ANGLE_WIDTH-1){1'b1}}};
    end else begin
      // Register writes
      if (cfg_write) begin
        case (cfg_index)
          jti_pkg::REG_MODE:        mode           <= cfg_data[0];
          jti_pkg::REG_DURATION:    duration_ticks <= cfg_data[TIME_WIDTH-1:0];
          jti_pkg::REG_START_ANGLE: start_angle    <= cfg_data[ANGLE_WIDTH-1:0];
          jti_pkg::REG_END_ANGLE:   end_angle      <= cfg_data[ANGLE_WIDTH-1:0];
          jti_pkg::REG_START_RATE:  start_rate     <= cfg_data[RATE_WIDTH-1:0];
          jti_pkg::REG_END_RATE:    end_rate       <= cfg_data[RATE_WIDTH-1:0];
          jti_pkg::REG_LOWER_LIMIT: lower_limit    <= cfg_data[ANGLE_WIDTH-1:0];
          jti_pkg::REG_UPPER_LIMIT: upper_limit    <= cfg_data[ANGLE_WIDTH-1:0];
          default: ;
        endcase
      end

      // Raise the result on emit, drop it once transferred
      if (st == S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (st)
        S_IDLE: begin
          if (accept) begin
            if (restart) begin
              if (restart_bad) begin
                phase <= PH_BADREQ;
                st    <= S_EMIT;
              end else begin
                phase   <= PH_RUN;
                elapsed <= '0;
                st      <= S_SSTART;
              end
            end else if (phase == PH_RUN) begin
              if (run_end) begin
                phase         <= PH_DONE;
                held_position <= end_angle;
                st            <= S_EMIT;
              end else begin
                st <= S_SSTART;
              end
            end else begin
              st <= S_EMIT;
            end
          end
        end
        S_SSTART: st <= S_SWAIT;
        S_SWAIT:  if (div_done) st <= S_MSTART;
        S_MSTART: st <= S_MWAIT;
        S_MWAIT: begin
          if (mul_done) begin
            st <= (!mode || op == OP_BASU) ? S_RSTART : S_MSTART;
          end
        end
        S_RSTART: st <= S_RWAIT;
        S_RWAIT:  if (div_done) st <= S_FIN;
        S_FIN: begin
          if (path_bad) begin
            phase <= PH_BADPATH;
          end else begin
            held_position <= pos_sat[ANGLE_WIDTH-1:0];
            elapsed       <= kq + TIME_WIDTH'(1);
          end
          st <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // Working values, staged result and output payload
  always_ff @(posedge clk) begin
    case (st)
      S_IDLE: begin
        if (accept) begin
          kq       <= restart ? '0 : elapsed;
          op       <= OP_DS;
          st_pos   <= (!restart && phase == PH_RUN) ? end_angle : held_position;
          st_rate  <= '0;
          st_fault <= acc_fault;
          st_done  <= acc_done;
        end
      end
      S_SWAIT: begin
        if (div_done) begin
          s_frac <= div_quot[QFRAC-1:0];
          num    <= d_q;
        end
      end
      S_MWAIT: begin
        if (mul_done) begin
          op <= op_t'(op + 4'd1);
          case (op)
            OP_DS:   pacc  <= q0_q + mul_res;
            OP_VT0:  a_r   <= mul_res - d_q;
            OP_VT1:  b_r   <= d_q - mul_res;
            OP_AU:   blend <= mul_res;
            OP_BS:   blend <= blend + mul_res;
            OP_SU:   su    <= mul_res[QFRAC:0];
            OP_BLSU: pacc  <= pacc + mul_res;
            OP_BLUS: num   <= d_q + mul_res;
            OP_BASU: num   <= num + mul_res;
            default: ;
          endcase
        end
      end
      S_RWAIT: begin
        if (div_done) begin
          r_q <= num[QW-1] ? $signed(-div_quot) : $signed(div_quot);
        end
      end
      S_FIN: begin
        if (path_bad) begin
          st_pos   <= held_position;
          st_rate  <= '0;
          st_fault <= jti_pkg::FAULT_PATH;
        end else begin
          st_pos   <= pos_sat[ANGLE_WIDTH-1:0];
          st_rate  <= rate_sat[RATE_WIDTH-1:0];
          st_fault <= jti_pkg::FAULT_NONE;
        end
        st_done <= 1'b0;
      end
      S_EMIT: begin
        if (out_free) begin
          position <= st_pos;
          rate     <= st_rate;
          fault    <= st_fault;
          done_res <= st_done;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/jti_mul.sv @@
// Shared multiplier: x * y, or trunc(x * y / 2^QFRAC) toward zero.
// One 32x32 product per cycle, two slices of |x|.
module jti_mul (
  input  logic                                     clk,
  input  logic                                     rst,
  input  jti_pkg::mul_req_t                        req,
  input  logic signed [jti_pkg::QW-1:0]            x,
  input  logic signed [jti_pkg::MUL_YW-1:0]        y,
  output logic                                     done,
  output logic signed [jti_pkg::QW-1:0]            result
);

  localparam int QW   = jti_pkg::QW;
  localparam int HALF = jti_pkg::MUL_HALF;
  localparam int YW   = jti_pkg::MUL_YW;
  localparam int ACCW = QW + HALF;

  typedef enum logic [4:0] {
    M_IDLE = 5'b00001,
    M_LO   = 5'b00010,
    M_HI   = 5'b00100,
    M_ACC  = 5'b01000,
    M_OUT  = 5'b10000
  } mstate_t;

  mstate_t           state;
  logic [QW-1:0]     mag_x;
  logic [HALF-1:0]   mag_y;
  logic              neg;
  logic              frac;
  logic [QW-1:0]     prod;
  logic [ACCW-1:0]   acc;
  logic [YW-1:0]     y_abs;
  logic [QW-1:0]     scaled;

  assign y_abs  = y[YW-1] ? YW'(-y) : YW'(y);
  assign scaled = frac ? acc[jti_pkg::QFRAC +: QW] : acc[QW-1:0];

  // Sequence the slices
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        M_IDLE: if (req.start) state <= M_LO;
        M_LO:   state <= M_HI;
        M_HI:   state <= M_ACC;
        M_ACC:  state <= M_OUT;
        M_OUT: begin
          done  <= 1'b1;
          state <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

  // Operands, partial products and accumulation
  always_ff @(posedge clk) begin
    case (state)
      M_IDLE: begin
        if (req.start) begin
          mag_x <= x[QW-1] ? QW'(-x) : QW'(x);
          mag_y <= y_abs[HALF-1:0];
          neg   <= x[QW-1] ^ y[YW-1];
          frac  <= req.frac;
        end
      end
      M_LO: prod <= QW'(mag_x[HALF-1:0]) * QW'(mag_y);
      M_HI: begin
        prod <= QW'(mag_x[QW-1:HALF]) * QW'(mag_y);
        acc  <= ACCW'(prod);
      end
      M_ACC: acc <= acc + {prod, HALF'(0)};
      M_OUT: result <= neg ? $signed(-scaled) : $signed(scaled);
      default: ;
    endcase
  end

endmodule

@@ rtl/jti_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Remainder starts at rem_init (below the divisor); num bits shift in MSB first.
module jti_div #(
  parameter int TIME_WIDTH = jti_pkg::TIME_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  jti_pkg::div_req_t             req,
  input  logic [TIME_WIDTH-1:0]         rem_init,
  input  logic [jti_pkg::QW-1:0]        num,
  input  logic [TIME_WIDTH-1:0]         divisor,
  output logic                          done,
  output logic [jti_pkg::QW-1:0]        quot
);

  localparam int QW = jti_pkg::QW;
  localparam int CW = jti_pkg::DIV_CNT_W;

  typedef enum logic [1:0] {
    D_IDLE = 2'b01,
    D_RUN  = 2'b10
  } dstate_t;

  dstate_t               state;
  logic [CW-1:0]         cnt;
  logic [TIME_WIDTH-1:0] rem;
  logic [QW-1:0]         num_sh;
  logic [TIME_WIDTH:0]   trial;
  logic                  fits;
  logic [TIME_WIDTH-1:0] rem_next;

  // Trial subtract
  always_comb begin
    trial    = {rem, num_sh[QW-1]};
    fits     = trial >= {1'b0, divisor};
    rem_next = fits ? TIME_WIDTH'(trial - {1'b0, divisor}) : trial[TIME_WIDTH-1:0];
  end

  // Count steps
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (req.start) begin
            cnt   <= req.count;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            done  <= 1'b1;
            state <= D_IDLE;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

  // Shift remainder, dividend and quotient
  always_ff @(posedge clk) begin
    if (state == D_IDLE) begin
      if (req.start) begin
        rem    <= rem_init;
        num_sh <= num;
      end
    end else begin
      rem    <= rem_next;
      num_sh <= {num_sh[QW-2:0], 1'b0};
      quot   <= {quot[QW-2:0], fits};
    end
  end

endmodule

@@ rtl/jti_checker.sv @@
`include "joint_trajectory_interpolator_macros.svh"

// Port-level checks on the trajectory block.
module jti_checker #(
  parameter int ANGLE_WIDTH = jti_pkg::ANGLE_WIDTH_DEF,
  parameter int RATE_WIDTH  = jti_pkg::RATE_WIDTH_DEF,
  parameter int TIME_WIDTH  = jti_pkg::TIME_WIDTH_DEF,
  localparam int CFG_W = (RATE_WIDTH >= ANGLE_WIDTH)
                         ? ((RATE_WIDTH >= TIME_WIDTH) ? RATE_WIDTH : TIME_WIDTH)
                         : ((ANGLE_WIDTH >= TIME_WIDTH) ? ANGLE_WIDTH : TIME_WIDTH)
) (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 restart,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [ANGLE_WIDTH-1:0]        position,
  input logic signed [RATE_WIDTH-1:0]         rate,
  input logic [1:0]                           fault,
  input logic                                 done_res,
  input logic                                 cfg_write,
  input logic [jti_pkg::REG_INDEX_WIDTH-1:0]  cfg_index,
  input logic [CFG_W-1:0]                     cfg_data
);

  // Hold a stalled result
  `JTI_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(position) && $stable(rate) && $stable(fault) && $stable(done_res), "result changed while stalled")

  // Not ready in the cycle after each input transfer
  `JTI_ASSERT_NEXT(a_busy_after_transfer, clk, rst, in_valid && in_ready, !in_ready, "ready stayed high after a transfer")

  // A faulted result carries zero rate and no done flag
  `JTI_ASSERT_IMPLY(a_fault_hold, clk, rst, out_valid && fault != jti_pkg::FAULT_NONE, rate == '0 && !done_res, "faulted result moves or reports done")

  // A finished move holds at zero rate without fault
  `JTI_ASSERT_IMPLY(a_done_hold, clk, rst, out_valid && done_res, rate == '0 && fault == jti_pkg::FAULT_NONE, "done result moves or reports a fault")

endmodule

bind joint_trajectory_interpolator jti_checker #(
  .ANGLE_WIDTH (ANGLE_WIDTH),
  .RATE_WIDTH  (RATE_WIDTH),
  .TIME_WIDTH  (TIME_WIDTH)
) u_jti_checker (.*);
